// ===== hdl/edu_pkg.sv =====
package edu_pkg;

  // component and accumulator widths
  localparam int ELEM_W = 16;
  localparam int SQ_W = 2 * ELEM_W;
  localparam int SUM_W = 40;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W = ROOT_W + 2;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W = $clog2(ROOT_STEPS);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic signed [ELEM_W-1:0] a_elem;
    logic signed [ELEM_W-1:0] b_elem;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic [ROOT_W-1:0] distance;
    logic [SUM_W-1:0]  squared_sum;
    logic              overflowed;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic fold;
    logic root_step;
    logic load_out;
  } cmd_t;

endpackage

// ===== hdl/edu_dp.sv =====
module edu_dp #(
  parameter int MAX_DIM = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  edu_pkg::cmd_t      cmd,
  input  edu_pkg::in_item_t  in_data,
  output edu_pkg::out_item_t out_data
);
  import edu_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIM);

  // difference and square
  logic signed [ELEM_W:0] diff;
  logic [ELEM_W:0]        diff_neg;
  logic [ELEM_W-1:0]      mag;
  logic [SQ_W-1:0]        sq;

  // square stage
  logic [SQ_W-1:0]  sq_r;
  logic             sq_over_r;
  logic             sq_vld_r;
  logic [CNT_W-1:0] cnt_r;

  // accumulator
  logic [SUM_W-1:0] acc_r;
  logic             over_r;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_total;

  // square root
  logic [SUM_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  rem_diff;
  logic              take;
  logic [SUM_W-1:0]  hold_sum_r;
  logic              hold_ovf_r;

  out_item_t out_r;

  assign diff     = {in_data.a_elem[ELEM_W-1], in_data.a_elem}
                  - {in_data.b_elem[ELEM_W-1], in_data.b_elem};
  assign diff_neg = (ELEM_W+1)'(0) - diff;
  assign mag      = diff[ELEM_W] ? diff_neg[ELEM_W-1:0] : diff[ELEM_W-1:0];
  assign sq       = SQ_W'(mag) * SQ_W'(mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      sq_vld_r <= cmd.accept;
      if (cmd.accept) begin
        if (in_data.last) begin
          cnt_r <= '0;
        end else if (cnt_r != CNT_MAX) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sq_r      <= sq;
      sq_over_r <= (cnt_r == CNT_MAX);
    end
  end

  assign sum_wide  = {1'b0, acc_r} + (SUM_W+1)'(sq_r);
  assign sum_total = (sq_over_r || sum_wide[SUM_W]) ? SUM_MAX : sum_wide[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      over_r <= 1'b0;
    end else if (cmd.fold) begin
      acc_r  <= '0;
      over_r <= 1'b0;
    end else if (sq_vld_r) begin
      acc_r  <= sum_total;
      over_r <= over_r | sq_over_r;
    end
  end

  // restoring square root, one result bit per step
  assign rem_sh   = {rem_r, rad_r[SUM_W-1 -: 2]};
  assign trial    = (REM_W+2)'({root_r, 2'b01});
  assign take     = (rem_sh >= trial);
  assign rem_diff = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (cmd.fold) begin
      rad_r      <= sum_total;
      rem_r      <= '0;
      root_r     <= '0;
      hold_sum_r <= sum_total;
      hold_ovf_r <= over_r | sq_over_r;
    end else if (cmd.root_step) begin
      rad_r  <= {rad_r[SUM_W-3:0], 2'b00};
      rem_r  <= take ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.distance    <= root_r;
      out_r.squared_sum <= hold_sum_r;
      out_r.overflowed  <= hold_ovf_r;
    end
  end

  assign out_data = out_r;

endmodule

// ===== hdl/edu_ctrl.sv =====
module edu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output edu_pkg::cmd_t cmd
);
  import edu_pkg::*;

  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_FOLD = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign in_stall   = (state_r != ST_ACC);
  assign out_valid  = out_valid_r;
  assign out_free   = !out_valid_r || !out_stall;

  assign cmd.accept    = in_valid && !in_stall;
  assign cmd.fold      = (state_r == ST_FOLD);
  assign cmd.root_step = (state_r == ST_ROOT);
  assign cmd.load_out  = (state_r == ST_DONE) && out_free;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_ACC: begin
        if (cmd.accept && in_last) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        state_nxt = ST_ROOT;
        step_nxt  = '0;
      end
      ST_ROOT: begin
        if (step_r == STEP_W'(ROOT_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_last_folds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_last) |=> (state_r == ST_FOLD))
    else $error("last item did not start fold");

  a_fold_to_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FOLD) |=> (state_r == ST_ROOT && step_r == '0))
    else $error("root did not start at step zero");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT) |-> (step_r < STEP_W'(ROOT_STEPS)))
    else $error("root step out of range");

  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !cmd.load_out) |=> !out_valid_r)
    else $error("taken result stayed valid");

endmodule

// ===== hdl/euclidean_distance_unit.sv =====
// channel | ports                          | payload
// --------+--------------------------------+------------------------------------
// input   | in_valid, in_stall, in_data    | a_elem, b_elem (q4.12), last
// result  | out_valid, out_stall, out_data | distance, squared_sum, overflowed
//
// non-last items are taken one per cycle; each square sits in a stage register
// before it is added to the 40-bit saturating accumulator
// a last item's result shows only after a fold step, then 20 steps of the
// shared bit-serial square root, then a load into the output register, which
// waits while the held result is still stalled; input is stalled over that span
// the output register decouples the result side, so the next vector streams in
// while a finished result still waits on out_stall
// rst_n is synchronous, active low; it clears the accumulator, pair count and
// overflow flag, no clearing pass is needed
module euclidean_distance_unit #(
  parameter int MAX_DIM = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  edu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output edu_pkg::out_item_t out_data
);
  import edu_pkg::*;

  // command bundle from the controller
  cmd_t cmd;

  // sequencer: accept, fold, root steps, result load
  edu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // square, accumulate, square root and output register
  edu_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ===== test/euclidean_distance_unit_test.sv =====
`timescale 1ns / 1ps

module euclidean_distance_unit_test;
  import edu_pkg::*;

  localparam int MAX_PAIRS = 256;
  localparam int HALF_PERIOD = 4;
  // cycles with no item moving on either side before the run is abandoned
  localparam int STUCK_LIMIT = 4000;
  // a last item's result shows only after the fold, root steps and output load
  localparam int TAIL_CYCLES = 40;

  localparam longint unsigned SUM_LIMIT = longint'(SUM_MAX);
  localparam longint unsigned ROOT_LIMIT = (64'd1 << ROOT_W) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  // distance state mirrored from the block
  longint unsigned acc_sum = 0;
  int pairs_seen = 0;
  bit too_many = 1'b0;

  // distances still owed by the block, oldest first
  out_item_t pending_results[$];

  int error_count = 0;
  int stuck_cycles = 0;

  // percent chance per cycle of a sender gap and of a receiver stall
  int idle_pct = 0;
  int stall_pct = 0;

  euclidean_distance_unit #(
    .MAX_DIM(MAX_PAIRS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // receiver back pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // floor square root, one result bit at a time from the top
  function automatic logic [ROOT_W-1:0] floor_root(input longint unsigned value);
    logic [ROOT_W-1:0] root;
    longint unsigned trial;
    root = '0;
    for (int bit_pos = ROOT_W - 1; bit_pos >= 0; bit_pos--) begin
      trial = longint'(root) | (64'd1 << bit_pos);
      if (trial * trial <= value) begin
        root = trial[ROOT_W-1:0];
      end
    end
    return root;
  endfunction

  // fold one accepted pair into the running sum; a last item yields a distance
  task automatic fold_pair(input in_item_t item);
    longint diff;
    longint unsigned mag;
    longint unsigned square;
    out_item_t result;
    diff = longint'(item.a_elem) - longint'(item.b_elem);
    mag = (diff < 0) ? longint'(-diff) : longint'(diff);
    square = (mag > ROOT_LIMIT) ? SUM_LIMIT : mag * mag;
    if (pairs_seen >= MAX_PAIRS) begin
      // extra pairs pin the sum and flag the vector
      too_many = 1'b1;
      acc_sum = SUM_LIMIT;
    end else begin
      pairs_seen++;
      if (square > SUM_LIMIT - acc_sum) begin
        acc_sum = SUM_LIMIT;
      end else begin
        acc_sum = acc_sum + square;
      end
    end
    if (item.last) begin
      result.distance = floor_root(acc_sum);
      result.squared_sum = acc_sum[SUM_W-1:0];
      result.overflowed = too_many;
      pending_results = {pending_results, result};
      acc_sum = 0;
      pairs_seen = 0;
      too_many = 1'b0;
    end
  endtask

  // present one item, hold it until taken, then predict its effect
  task automatic send_item(input logic signed [ELEM_W-1:0] a_val,
                           input logic signed [ELEM_W-1:0] b_val,
                           input logic last_flag);
    in_item_t item;
    item.a_elem = a_val;
    item.b_elem = b_val;
    item.last = last_flag;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do begin
      @(posedge clk);
    end while (in_stall);
    fold_pair(item);
  endtask

  // mostly uniform components, with a fair share of the corners
  function automatic logic signed [ELEM_W-1:0] pick_elem();
    case ($urandom_range(11))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      3: return -16'sd1;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic send_vector(input int length);
    for (int idx = 0; idx < length; idx++) begin
      send_item(pick_elem(), pick_elem(), idx == length - 1);
    end
  endtask

  // sender holds off until every owed distance has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_single_pairs();
    // one-component vectors, mostly at the field corners
    send_item('0, '0, 1'b1);
    send_item(-16'sd32768, 16'sd32767, 1'b1);
    send_item(16'sd32767, -16'sd32768, 1'b1);
    send_item(16'sd32767, 16'sd32767, 1'b1);
    send_item(-16'sd32768, -16'sd32768, 1'b1);
    send_item(-16'sd1, '0, 1'b1);
    send_item(16'sd1, -16'sd1, 1'b1);
    send_item(16'sd4096, '0, 1'b1);
    send_item(16'h5555, 16'shaaaa, 1'b1);
  endtask

  task automatic test_short_vectors();
    send_item(16'sd1, '0, 1'b0);
    send_item('0, -16'sd1, 1'b0);
    send_item(-16'sd1, 16'sd1, 1'b1);
    send_item(16'sd32767, '0, 1'b0);
    send_item('0, 16'sd32767, 1'b1);
    send_item(-16'sd32768, 16'sd32767, 1'b0);
    send_item(16'sd32767, -16'sd32768, 1'b0);
    send_item(16'shaaaa, 16'h5555, 1'b0);
    send_item(16'sd12288, -16'sd4096, 1'b1);
    send_item('0, '0, 1'b0);
    send_item('0, '0, 1'b1);
  endtask

  task automatic test_full_length();
    // exactly the maximum number of pairs, first all at the widest difference, then random
    for (int idx = 0; idx < MAX_PAIRS; idx++) begin
      send_item(-16'sd32768, 16'sd32767, idx == MAX_PAIRS - 1);
    end
    send_vector(MAX_PAIRS);
  endtask

  task automatic test_too_many_pairs();
    // one pair past the maximum, then a longer run of extras
    send_vector(MAX_PAIRS + 1);
    send_vector(MAX_PAIRS + 37);
    // the vector after an overflowed one must start clean
    send_item(16'sd2, -16'sd2, 1'b1);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int hold_pct,
                                     input int item_count);
    int sent;
    int length;
    idle_pct = gap_pct;
    stall_pct = hold_pct;
    sent = 0;
    while (sent < item_count) begin
      case ($urandom_range(99)) inside
        [0:74]: length = $urandom_range(6, 1);
        [75:94]: length = $urandom_range(32, 7);
        [95:98]: length = $urandom_range(MAX_PAIRS, MAX_PAIRS - 16);
        default: length = $urandom_range(MAX_PAIRS + 6, MAX_PAIRS + 1);
      endcase
      // the last vector of a phase is cut to the items left
      if (length > item_count - sent) begin
        length = item_count - sent;
      end
      send_vector(length);
      sent += length;
    end
    wait_drained();
  endtask

  // result side: each distance against the oldest one owed
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected distance item, actual %p", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.distance !== want.distance) begin
          error_count++;
          $display("%0t: distance expected %0d actual %0d", $time,
                   want.distance, out_data.distance);
        end
        if (out_data.squared_sum !== want.squared_sum) begin
          error_count++;
          $display("%0t: squared_sum expected %0d actual %0d", $time,
                   want.squared_sum, out_data.squared_sum);
        end
        if (out_data.overflowed !== want.overflowed) begin
          error_count++;
          $display("%0t: overflowed expected %0b actual %0b", $time,
                   want.overflowed, out_data.overflowed);
        end
      end
    end
  end

  // watchdog: any item moving on either side counts as progress
  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part runs with both sides streaming freely
    test_single_pairs();
    test_short_vectors();
    wait_drained();
    test_full_length();
    test_too_many_pairs();
    wait_drained();

    // random vectors under each idling pattern
    test_random_traffic(0, 0, 80);
    test_random_traffic(80, 0, 80);
    test_random_traffic(0, 80, 80);
    test_random_traffic(37, 37, 80);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/edu_pkg.sv
hdl/edu_dp.sv
hdl/edu_ctrl.sv
hdl/euclidean_distance_unit.sv
test/euclidean_distance_unit_test.sv
